@@ hw/rtl/psm_pkg.sv @@
// Shared types, register indexes and the scaled-division step of the source mapper.
package psm_pkg;

    localparam int DET_W  = 60;
    localparam int CFG_W  = 36;
    localparam int COORD_W = 16;

    typedef enum logic [2:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_EDGE_U_X      = 3'd2,
        REG_EDGE_U_Y      = 3'd3,
        REG_EDGE_V_X      = 3'd4,
        REG_EDGE_V_Y      = 3'd5,
        REG_SOURCE_WIDTH  = 3'd6,
        REG_SOURCE_HEIGHT = 3'd7
    } cfg_reg_t;

    // One beat travelling down the division chain.
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [DET_W-1:0]     num_x;
        logic [DET_W-1:0]     num_y;
        logic [DET_W-1:0]     rem_x;
        logic [DET_W-1:0]     rem_y;
    } psm_item_t;

    typedef struct packed {
        logic [DET_W-1:0] rem;
        logic [1:0]       inc;
    } psm_step_t;

    // One bit of floor(num * mult / den): double the remainder, then add num
    // when the multiplier bit is set, each time folding back below den.
    function automatic psm_step_t psm_step(input logic [DET_W-1:0] rem,
                                           input logic [DET_W-1:0] num,
                                           input logic [DET_W-1:0] den,
                                           input logic             add_bit);
        logic [DET_W-1:0] gap_d;
        logic [DET_W-1:0] gap_n;
        logic [DET_W-1:0] r1;
        psm_step_t        res;
        gap_d   = den - rem;
        gap_n   = den - num;
        res.inc = 2'd0;
        if (rem >= gap_d)
        begin
            r1      = rem - gap_d;
            res.inc = 2'd1;
        end
        else
        begin
            r1 = rem + rem;
        end
        res.rem = r1;
        if (add_bit)
        begin
            if (r1 >= gap_n)
            begin
                res.rem = r1 - gap_n;
                res.inc = res.inc + 2'd1;
            end
            else
            begin
                res.rem = r1 + num;
            end
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/psm_div_cell.sv @@
// One cell of the division chain: one quotient bit for each axis per beat.
module psm_div_cell
    import psm_pkg::*;
#(
    parameter int Q_W = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 add_bit_x,
    input  logic                 add_bit_y,
    input  logic [DET_W-1:0]     den,
    input  psm_item_t            item_in,
    input  logic [Q_W-1:0]       q_x_in,
    input  logic [Q_W-1:0]       q_y_in,
    output psm_item_t            item_out,
    output logic [Q_W-1:0]       q_x_out,
    output logic [Q_W-1:0]       q_y_out
);

    psm_item_t      item_reg;
    psm_item_t      item_next;
    logic [Q_W-1:0] q_x_reg;
    logic [Q_W-1:0] q_y_reg;
    logic [Q_W-1:0] q_x_next;
    logic [Q_W-1:0] q_y_next;
    psm_step_t      sx;
    psm_step_t      sy;

    always_comb
    begin
        sx        = psm_step(item_in.rem_x, item_in.num_x, den, add_bit_x);
        sy        = psm_step(item_in.rem_y, item_in.num_y, den, add_bit_y);
        item_next = item_in;
        item_next.rem_x = sx.rem;
        item_next.rem_y = sy.rem;
        q_x_next  = {q_x_in[Q_W-2:0], 1'b0} + Q_W'(sx.inc);
        q_y_next  = {q_y_in[Q_W-2:0], 1'b0} + Q_W'(sy.inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
            q_x_reg  <= '0;
            q_y_reg  <= '0;
        end
        else if (adv)
        begin
            item_reg <= item_next;
            q_x_reg  <= q_x_next;
            q_y_reg  <= q_y_next;
        end
    end

    assign item_out = item_reg;
    assign q_x_out  = q_x_reg;
    assign q_y_out  = q_y_reg;

endmodule

@@ hw/rtl/psm_front.sv @@
// Front pipeline: offset from origin, split cross products, range test.
module psm_front
    import psm_pkg::*;
#(
    parameter int DEST_COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [COORD_W-1:0]      dest_x,
    input  logic [COORD_W-1:0]      dest_y,
    input  logic signed [35:0]      origin_x,
    input  logic signed [35:0]      origin_y,
    input  logic signed [29:0]      edge_u_x,
    input  logic signed [29:0]      edge_u_y,
    input  logic signed [29:0]      edge_v_x,
    input  logic signed [29:0]      edge_v_y,
    input  logic [DET_W-1:0]        det_mag,
    input  logic                    det_rev,
    output psm_item_t               item_out
);

    localparam logic [COORD_W-1:0] CMASK = (DEST_COORD_BITS >= COORD_W) ? '1 :
        COORD_W'((32'd1 << DEST_COORD_BITS) - 32'd1);

    // Stage 0: captured beat.
    logic               v0_reg;
    logic [COORD_W-1:0] x0_reg, y0_reg;
    // Stage 1: offsets from the origin.
    logic               v1_reg;
    logic [COORD_W-1:0] x1_reg, y1_reg;
    logic signed [36:0] rx_reg, ry_reg;
    // Stage 2: partial products, high and low halves of the offsets.
    logic               v2_reg;
    logic [COORD_W-1:0] x2_reg, y2_reg;
    logic signed [47:0] a_hi_reg, b_hi_reg, c_hi_reg, d_hi_reg;
    logic signed [49:0] a_lo_reg, b_lo_reg, c_lo_reg, d_lo_reg;
    // Stage 3: cross products.
    logic               v3_reg;
    logic [COORD_W-1:0] x3_reg, y3_reg;
    logic signed [67:0] u_reg, w_reg;
    // Stage 4: orientation fix and range test.
    psm_item_t          out_reg;

    logic signed [36:0] rx_next, ry_next;
    logic signed [17:0] rx_hi, ry_hi;
    logic signed [19:0] rx_lo, ry_lo;
    logic signed [67:0] pa, pb, pc, pd;
    logic signed [67:0] un, wn;
    psm_item_t          out_next;

    always_comb
    begin
        rx_next = $signed({17'b0, x0_reg & CMASK, 4'b0}) - 37'(origin_x);
        ry_next = $signed({17'b0, y0_reg & CMASK, 4'b0}) - 37'(origin_y);
        rx_hi   = rx_reg[36:19];
        ry_hi   = ry_reg[36:19];
        rx_lo   = $signed({1'b0, rx_reg[18:0]});
        ry_lo   = $signed({1'b0, ry_reg[18:0]});
        pa = (68'(a_hi_reg) <<< 19) + 68'(a_lo_reg);
        pb = (68'(b_hi_reg) <<< 19) + 68'(b_lo_reg);
        pc = (68'(c_hi_reg) <<< 19) + 68'(c_lo_reg);
        pd = (68'(d_hi_reg) <<< 19) + 68'(d_lo_reg);
        un = det_rev ? -u_reg : u_reg;
        wn = det_rev ? -w_reg : w_reg;
        out_next        = '0;
        out_next.valid  = v3_reg;
        out_next.x      = x3_reg;
        out_next.y      = y3_reg;
        out_next.hit    = (un[67:DET_W] == '0) && (un[DET_W-1:0] < det_mag) &&
                          (wn[67:DET_W] == '0) && (wn[DET_W-1:0] < det_mag);
        out_next.num_x  = un[DET_W-1:0];
        out_next.num_y  = wn[DET_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            out_reg <= '0;
        end
        else if (adv)
        begin
            v0_reg  <= in_valid;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg   <= dest_x;
            y0_reg   <= dest_y;
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            a_hi_reg <= rx_hi * edge_v_y;
            a_lo_reg <= rx_lo * edge_v_y;
            b_hi_reg <= ry_hi * edge_v_x;
            b_lo_reg <= ry_lo * edge_v_x;
            c_hi_reg <= ry_hi * edge_u_x;
            c_lo_reg <= ry_lo * edge_u_x;
            d_hi_reg <= rx_hi * edge_u_y;
            d_lo_reg <= rx_lo * edge_u_y;
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            u_reg    <= pa - pb;
            w_reg    <= pc - pd;
        end
    end

    assign item_out = out_reg;

endmodule

@@ hw/rtl/parallelogram_source_mapper.sv @@
// Top level of the parallelogram source mapper: config, chain and output skid.
// Path: front stages, one division cell per quotient bit, then the output register.
// Throughput: one beat per cycle while the skid stage is empty; each cell of the division
// chain resolves one quotient bit per axis; cross products are split in two halves over
// one register stage. Reset clears all valid flags, sets the edges and origin to zero and
// the source sizes to one; the determinant registers follow the edges through det_a_reg and det_b_reg.
module parallelogram_source_mapper
    import psm_pkg::*;
#(
    parameter int DEST_COORD_BITS  = 16,
    parameter int SOURCE_SIZE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] dest_x,
    input  logic [COORD_W-1:0] dest_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               inside_res,
    output logic [COORD_W-1:0] source_offset_x,
    output logic [COORD_W-1:0] source_offset_y,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y
);

    localparam int QW = SOURCE_SIZE_BITS;

    // Configuration registers, written by the user only while the block is idle; not enforced.
    logic signed [35:0] origin_x_reg, origin_y_reg;
    logic signed [29:0] edge_u_x_reg, edge_u_y_reg, edge_v_x_reg, edge_v_y_reg;
    logic [15:0]        width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            edge_u_x_reg <= '0;
            edge_u_y_reg <= '0;
            edge_v_x_reg <= '0;
            edge_v_y_reg <= '0;
            width_reg    <= 16'd1;
            height_reg   <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:      origin_x_reg <= cfg_data;
                REG_ORIGIN_Y:      origin_y_reg <= cfg_data;
                REG_EDGE_U_X:      edge_u_x_reg <= cfg_data[29:0];
                REG_EDGE_U_Y:      edge_u_y_reg <= cfg_data[29:0];
                REG_EDGE_V_X:      edge_v_x_reg <= cfg_data[29:0];
                REG_EDGE_V_Y:      edge_v_y_reg <= cfg_data[29:0];
                REG_SOURCE_WIDTH:  width_reg    <= cfg_data[15:0];
                REG_SOURCE_HEIGHT: height_reg   <= cfg_data[15:0];
                default:           width_reg    <= width_reg;
            endcase
        end
    end

    // The determinant runs continuously off the edge registers: the two
    // products are registered, then their difference gives magnitude and sign.
    // A zero determinant leaves no pixel inside since nothing is below zero.
    logic signed [59:0] det_a_reg, det_b_reg;
    logic [DET_W-1:0]   det_mag_reg;
    logic               det_rev_reg;
    logic signed [60:0] det_diff;

    assign det_diff = 61'(det_a_reg) - 61'(det_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_a_reg   <= '0;
            det_b_reg   <= '0;
            det_mag_reg <= '0;
            det_rev_reg <= 1'b0;
        end
        else
        begin
            det_a_reg   <= edge_u_x_reg * edge_v_y_reg;
            det_b_reg   <= edge_u_y_reg * edge_v_x_reg;
            det_rev_reg <= det_diff[60];
            det_mag_reg <= det_diff[60] ? DET_W'(-det_diff) : DET_W'(det_diff);
        end
    end

    // The whole pipeline moves while the skid stage is empty; the skid catches
    // the one beat that can arrive while the output register is stalled.
    logic       skid_full_reg;
    logic       adv;

    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg;

    psm_item_t      chain [0:QW];
    logic [QW-1:0]  q_x [0:QW];
    logic [QW-1:0]  q_y [0:QW];
    logic [QW+15:0] wext;
    logic [QW+15:0] hext;

    assign wext = {{QW{1'b0}}, width_reg};
    assign hext = {{QW{1'b0}}, height_reg};

    psm_front #(
        .DEST_COORD_BITS (DEST_COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .dest_x   (dest_x),
        .dest_y   (dest_y),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .edge_u_x (edge_u_x_reg),
        .edge_u_y (edge_u_y_reg),
        .edge_v_x (edge_v_x_reg),
        .edge_v_y (edge_v_y_reg),
        .det_mag  (det_mag_reg),
        .det_rev  (det_rev_reg),
        .item_out (chain[0])
    );

    // Remainders start at zero; the quotient starts at zero.
    assign q_x[0] = '0;
    assign q_y[0] = '0;

    // Cell i takes the multiplier bit from the top down, like a long
    // multiplication folded into the remainder.
    genvar gi;
    generate
        for (gi = 0; gi < QW; gi++)
        begin : g_cell
            psm_item_t cell_in;
            always_comb
            begin
                cell_in = chain[gi];
                if (gi == 0)
                begin
                    cell_in.rem_x = '0;
                    cell_in.rem_y = '0;
                end
            end
            psm_div_cell #(
                .Q_W (QW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .add_bit_x (wext[QW-1-gi]),
                .add_bit_y (hext[QW-1-gi]),
                .den       (det_mag_reg),
                .item_in   (cell_in),
                .q_x_in    (q_x[gi]),
                .q_y_in    (q_y[gi]),
                .item_out  (chain[gi+1]),
                .q_x_out   (q_x[gi+1]),
                .q_y_out   (q_y[gi+1])
            );
        end
    endgenerate

    // Result fields of the last cell; offsets read zero for an outside pixel.
    logic        fin_valid;
    logic [64:0] fin_data;

    assign fin_valid = chain[QW].valid;
    assign fin_data  = {chain[QW].hit,
                        chain[QW].hit ? COORD_W'(q_x[QW]) : {COORD_W{1'b0}},
                        chain[QW].hit ? COORD_W'(q_y[QW]) : {COORD_W{1'b0}},
                        chain[QW].x, chain[QW].y};

    logic        out_valid_reg;
    logic [64:0] out_data_reg;
    logic [64:0] skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (!out_stall)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= fin_valid;
        end
        else if (fin_valid)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (!out_stall)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_data_reg <= fin_data;
        end
        else
        begin
            skid_data_reg <= fin_data;
        end
    end

    assign out_valid       = out_valid_reg;
    assign inside_res      = out_data_reg[64];
    assign source_offset_x = out_data_reg[63:48];
    assign source_offset_y = out_data_reg[47:32];
    assign out_x           = out_data_reg[31:16];
    assign out_y           = out_data_reg[15:0];

    // The skid stage only ever fills behind a stalled, valid output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while the output register is empty");

    // A skid beat drains as soon as the output side stops stalling.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && !out_stall) |=> !skid_full_reg)
        else $error("skid stage did not drain");

    // An outside pixel never carries a source offset.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !inside_res) |-> (source_offset_x == '0 && source_offset_y == '0))
        else $error("outside pixel with nonzero offset");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the parallelogram source mapper, with directed and random pixels.
module tb_top;
    import psm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One destination pixel as the block should map it.
    typedef struct {
        logic               hit;
        logic [COORD_W-1:0] off_x;
        logic [COORD_W-1:0] off_y;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } mapped_pixel_t;

    // One row of the directed table. Rows with a typed answer carry it in
    // known/hit/off_x/off_y; the rest are left to the predictor.
    typedef struct {
        int                 window;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        bit                 known;
        logic               hit;
        logic [COORD_W-1:0] off_x;
        logic [COORD_W-1:0] off_y;
    } pixel_row_t;

    localparam longint EDGE_MAX = 64'sd536870911;
    localparam longint EDGE_MIN = -64'sd536870912;
    localparam longint ORG_MAX  = 64'sd34359738367;
    localparam longint ORG_MIN  = -64'sd34359738368;
    localparam int     DRAIN_CYCLES = 40;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic               out_valid;
    logic               out_stall;
    logic               inside_res;
    logic [COORD_W-1:0] source_offset_x;
    logic [COORD_W-1:0] source_offset_y;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;

    // Our own copy of the register file, at the block's widths.
    logic signed [35:0] org_x, org_y;
    logic signed [29:0] eu_x, eu_y, ev_x, ev_y;
    logic [15:0]        src_w, src_h;

    mapped_pixel_t pending_pixels[$];
    int            mismatches;
    bit            quiet;

    parallelogram_source_mapper dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .dest_x(dest_x), .dest_y(dest_y),
        .out_valid(out_valid), .out_stall(out_stall), .inside_res(inside_res),
        .source_offset_x(source_offset_x), .source_offset_y(source_offset_y),
        .out_x(out_x), .out_y(out_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: a hung handshake must not hang the run.
    initial
    begin
        #3000000;
        $display("parallelogram_source_mapper verification failed");
        $finish;
    end

    // Inverse mapping of one pixel. All products are taken in 128 bits so the
    // cross products stay exact even for the most negative edge value -2^29.
    function automatic mapped_pixel_t map_pixel(input logic [15:0] px, input logic [15:0] py);
        logic signed [127:0] rx, ry, u, v, det, ox_w, oy_w, ux, uy, vx, vy;
        logic [127:0]        dmag, qx, qy;
        mapped_pixel_t       r;
        ox_w = org_x;
        oy_w = org_y;
        ux   = eu_x;
        uy   = eu_y;
        vx   = ev_x;
        vy   = ev_y;
        rx   = $signed({112'd0, px}) * 128'sd16 - ox_w;
        ry   = $signed({112'd0, py}) * 128'sd16 - oy_w;
        det  = ux * vy - uy * vx;
        u    = rx * vy - ry * vx;
        v    = ux * ry - uy * rx;
        // A clockwise parallelogram flips the sign of both coordinates.
        if (det < 0)
        begin
            det = -det;
            u   = -u;
            v   = -v;
        end
        dmag = {68'd0, det[59:0]};
        r.hit    = (u >= 0) && ($unsigned(u) < dmag) && (v >= 0) && ($unsigned(v) < dmag);
        r.off_x  = '0;
        r.off_y  = '0;
        if (r.hit)
        begin
            qx      = ($unsigned(u) * {112'd0, src_w}) / dmag;
            qy      = ($unsigned(v) * {112'd0, src_h}) / dmag;
            r.off_x = qx[15:0];
            r.off_y = qy[15:0];
        end
        r.px = px;
        r.py = py;
        return r;
    endfunction

    // The receiving side: random stall and the check of each result beat.
    always @(posedge clk)
    begin
        mapped_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected beat x=%0d y=%0d", $time, out_x, out_y);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (inside_res !== want.hit)
                begin
                    $display("%0t: inside_res expected %0d actual %0d", $time, want.hit,
                             inside_res);
                    mismatches = mismatches + 1;
                end
                if (source_offset_x !== want.off_x)
                begin
                    $display("%0t: source_offset_x expected %0d actual %0d", $time,
                             want.off_x, source_offset_x);
                    mismatches = mismatches + 1;
                end
                if (source_offset_y !== want.off_y)
                begin
                    $display("%0t: source_offset_y expected %0d actual %0d", $time,
                             want.off_y, source_offset_y);
                    mismatches = mismatches + 1;
                end
                if (out_x !== want.px)
                begin
                    $display("%0t: out_x expected %0d actual %0d", $time, want.px, out_x);
                    mismatches = mismatches + 1;
                end
                if (out_y !== want.py)
                begin
                    $display("%0t: out_y expected %0d actual %0d", $time, want.py, out_y);
                    mismatches = mismatches + 1;
                end
            end
        end
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 14);
    end

    // Offers one pixel beat, holding it until accepted, then records what the
    // block owes for it.
    task automatic send_pixel(input logic [15:0] px, input logic [15:0] py, input bit known,
                              input logic k_in, input logic [15:0] k_ox,
                              input logic [15:0] k_oy);
        mapped_pixel_t want;
        if (!quiet && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        dest_x   <= px;
        dest_y   <= py;
        do
            @(posedge clk);
        while (in_stall);
        if (known)
        begin
            want.hit    = k_in;
            want.off_x  = k_ox;
            want.off_y  = k_oy;
            want.px     = px;
            want.py     = py;
        end
        else
        begin
            want = map_pixel(px, py);
        end
        pending_pixels.push_back(want);
    endtask

    // Waits until every owed beat has come back, then lets the chain empty.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input longint value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
    endtask

    // Loads a whole window into the block and into our mirror. Only called
    // while the block is idle.
    task automatic set_window(input longint ox, input longint oy, input longint ux,
                              input longint uy, input longint vx, input longint vy,
                              input int w, input int h);
        org_x = ox[35:0];
        org_y = oy[35:0];
        eu_x  = ux[29:0];
        eu_y  = uy[29:0];
        ev_x  = vx[29:0];
        ev_y  = vy[29:0];
        src_w = w[15:0];
        src_h = h[15:0];
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_EDGE_U_X, ux);
        write_reg(REG_EDGE_U_Y, uy);
        write_reg(REG_EDGE_V_X, vx);
        write_reg(REG_EDGE_V_Y, vy);
        write_reg(REG_SOURCE_WIDTH, longint'(w));
        write_reg(REG_SOURCE_HEIGHT, longint'(h));
        cfg_write <= 1'b0;
        // Waits for the determinant registers to settle after the last write.
        repeat (4) @(posedge clk);
    endtask

    function automatic longint clamp_px(input longint val);
        if (val < 0)
            return 0;
        if (val > 65535)
            return 65535;
        return val;
    endfunction

    function automatic longint rand_edge;
        longint mag;
        mag = longint'($urandom_range(1, 1500)) * 16 + $urandom_range(0, 15);
        return $urandom_range(1) ? mag : -mag;
    endfunction

    pixel_row_t pixel_table[] = '{
        // After reset the determinant is zero: nothing is inside.
        '{0, 16'd0,     16'd0,     1'b1, 1'b0, 16'd0,  16'd0},
        '{0, 16'd65535, 16'd65535, 1'b1, 1'b0, 16'd0,  16'd0},
        '{0, 16'h5555,  16'haaaa,  1'b1, 1'b0, 16'd0,  16'd0},
        // A 100 by 100 square at the origin mapped onto a 100 by 100 source.
        '{1, 16'd0,     16'd0,     1'b1, 1'b1, 16'd0,  16'd0},
        '{1, 16'd99,    16'd99,    1'b1, 1'b1, 16'd99, 16'd99},
        '{1, 16'd50,    16'd25,    1'b1, 1'b1, 16'd50, 16'd25},
        '{1, 16'd100,   16'd5,     1'b1, 1'b0, 16'd0,  16'd0},
        '{1, 16'd5,     16'd100,   1'b1, 1'b0, 16'd0,  16'd0},
        '{1, 16'd65535, 16'd65535, 1'b1, 1'b0, 16'd0,  16'd0},
        // Same square with the edges swapped: reversed orientation, axes swap.
        '{2, 16'd10,    16'd20,    1'b1, 1'b1, 16'd20, 16'd10},
        '{2, 16'd0,     16'd99,    1'b1, 1'b1, 16'd99, 16'd0},
        '{2, 16'd99,    16'd100,   1'b1, 1'b0, 16'd0,  16'd0},
        // Edges at -2^29, origin at its extremes, width at maximum, height zero.
        '{3, 16'd0,     16'd0,     1'b0, 1'b0, 16'd0,  16'd0},
        '{3, 16'd65535, 16'd65535, 1'b0, 1'b0, 16'd0,  16'd0},
        '{3, 16'd65535, 16'd0,     1'b0, 1'b0, 16'd0,  16'd0},
        '{3, 16'd1,     16'd65534, 1'b0, 1'b0, 16'd0,  16'd0},
        // Largest edges from the origin, full-size source.
        '{4, 16'd0,     16'd0,     1'b0, 1'b0, 16'd0,  16'd0},
        '{4, 16'd65535, 16'd65535, 1'b0, 1'b0, 16'd0,  16'd0},
        '{4, 16'd12345, 16'd54321, 1'b0, 1'b0, 16'd0,  16'd0}
    };

    initial
    begin
        int     cur_window;
        longint lo_x, hi_x, lo_y, hi_y;
        longint ux, uy, vx, vy, ox, oy;
        int     w, h;
        logic [15:0] px, py;

        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_ORIGIN_X;
        cfg_data   = '0;
        in_valid   = 1'b0;
        dest_x     = '0;
        dest_y     = '0;
        out_stall  = 1'b0;
        mismatches = 0;
        quiet      = 1'b0;
        org_x = '0;
        org_y = '0;
        eu_x  = '0;
        eu_y  = '0;
        ev_x  = '0;
        ev_y  = '0;
        src_w = 16'd1;
        src_h = 16'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: each change of window waits for an empty pipeline.
        cur_window = 0;
        foreach (pixel_table[i])
        begin
            if (pixel_table[i].window != cur_window)
            begin
                drain();
                cur_window = pixel_table[i].window;
                case (cur_window)
                    1: set_window(0, 0, 1600, 0, 0, 1600, 100, 100);
                    2: set_window(0, 0, 0, 1600, 1600, 0, 100, 100);
                    3: set_window(ORG_MAX, ORG_MIN, EDGE_MIN, 0, 0, EDGE_MIN, 65535, 0);
                    default: set_window(0, 0, EDGE_MAX, 0, 0, EDGE_MAX, 65535, 65535);
                endcase
            end
            send_pixel(pixel_table[i].px, pixel_table[i].py, pixel_table[i].known,
                       pixel_table[i].hit, pixel_table[i].off_x, pixel_table[i].off_y);
        end

        // Random part: eight windows, most pixels aimed at the parallelogram's
        // bounding box so that the inside path and the division see real work.
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            quiet = (phase == 3);
            ox = longint'($urandom_range(0, 3000)) * 16 + $urandom_range(0, 15);
            oy = longint'($urandom_range(0, 3000)) * 16 + $urandom_range(0, 15);
            ux = rand_edge();
            uy = rand_edge();
            vx = rand_edge();
            vy = rand_edge();
            w  = $urandom_range(0, 65535);
            h  = $urandom_range(1, 300);
            case (phase)
                0:
                begin
                    ux = EDGE_MAX;
                    uy = EDGE_MIN;
                    vx = EDGE_MAX;
                    vy = EDGE_MAX;
                    w  = 65535;
                    h  = 65535;
                end
                1:
                begin
                    w = 1;
                    h = 0;
                end
                2:
                begin
                    // Parallel edges give a zero determinant.
                    vx = 2 * ux;
                    vy = 2 * uy;
                end
                default: ;
            endcase
            set_window(ox, oy, ux, uy, vx, vy, w, h);
            lo_x = clamp_px((ox + ((ux < 0) ? ux : 0) + ((vx < 0) ? vx : 0)) / 16 - 2);
            hi_x = clamp_px((ox + ((ux > 0) ? ux : 0) + ((vx > 0) ? vx : 0)) / 16 + 2);
            lo_y = clamp_px((oy + ((uy < 0) ? uy : 0) + ((vy < 0) ? vy : 0)) / 16 - 2);
            hi_y = clamp_px((oy + ((uy > 0) ? uy : 0) + ((vy > 0) ? vy : 0)) / 16 + 2);
            for (int n = 0; n < 167; n++)
            begin
                if ($urandom_range(99) < 75)
                begin
                    px = 16'(lo_x + $urandom_range(0, int'(hi_x - lo_x)));
                    py = 16'(lo_y + $urandom_range(0, int'(hi_y - lo_y)));
                end
                else
                begin
                    px = 16'($urandom_range(0, 65535));
                    py = 16'($urandom_range(0, 65535));
                end
                send_pixel(px, py, 1'b0, 1'b0, 16'd0, 16'd0);
            end
        end

        quiet = 1'b0;
        drain();
        if (mismatches == 0)
            $display("parallelogram_source_mapper verification clean");
        else
            $display("parallelogram_source_mapper verification failed");
        $finish;
    end

endmodule
